### rtl/ffba_pkg.sv
// shared constants and word types of the first-fit block allocator
package ffba_pkg;

	localparam int POOL_BYTES   = 4096;
	localparam int MAX_SEGMENTS = 64;
	localparam int HEADER_BYTES = 16;

	localparam int SW = 13;                          // size and offset field width
	localparam int IW = $clog2(MAX_SEGMENTS);        // table index
	localparam int CW = $clog2(MAX_SEGMENTS + 1);    // segment count
	localparam int PW = SW + 1;                      // running pool position

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_MERGE = 2'd2
	} cmd_code_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_FIT   = 2'd1,
		ST_BAD_FREE = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		cmd_code_t       command;
		logic [SW-1:0]   request_bytes;
		logic [SW-1:0]   release_offset;
	} cmd_t;

	typedef struct packed {
		status_t         status;
		logic [SW-1:0]   data_offset;
		logic [SW-1:0]   free_total;
	} rsp_t;

	typedef struct packed {
		logic            free;
		logic [SW-1:0]   size;
	} seg_t;

endpackage

### rtl/first_fit_block_allocator.sv
// first-fit allocator: segment table in one memory, walked one entry per cycle
// alloc/free scan the table; a split then shifts the tail up and rewrites
//   the hit and the new free entry, merge compacts the table, and each
//   command ends in the result register
// throughput: one word at a time, bounded by the single table read port
// reset: S_INIT then seeds table entry 0 with the whole pool as free
module first_fit_block_allocator import ffba_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	typedef enum logic [2:0] {
		S_INIT, S_IDLE, S_SCAN, S_MERGE, S_SHIFT, S_SPLIT1, S_SPLIT2, S_RESP
	} state_t;

	seg_t mem [MAX_SEGMENTS];
	seg_t rd_q;

	state_t          state_q;
	cmd_t            cmd_q;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   ra_q;
	logic            v_s1;
	logic [IW-1:0]   idx_s1;
	logic [PW-1:0]   pos_q;
	logic [IW-1:0]   hit_q;
	logic [SW-1:0]   sz_q;
	logic [SW-1:0]   off_q;
	logic [IW-1:0]   wr_q;
	seg_t            acc_q;
	logic [SW-1:0]   ft_q;
	logic            we_q;
	logic [IW-1:0]   wa_q;
	seg_t            wd_q;
	status_t         res_status_q;
	logic [SW-1:0]   res_off_q;
	logic            rsp_valid_q;
	rsp_t            rsp_q;

	logic            hit_c;
	logic [PW-1:0]   req_hdr_c;

	always_ff @(posedge clk) begin
		if (we_q)
			mem[wa_q] <= wd_q;
		rd_q <= mem[ra_q[IW-1:0]];
	end

	assign req_hdr_c = PW'(cmd_q.request_bytes) + PW'(HEADER_BYTES);

	always_comb begin
		if (cmd_q.command == CMD_ALLOC)
			hit_c = rd_q.free && (rd_q.size >= cmd_q.request_bytes);
		else
			hit_c = (pos_q + PW'(HEADER_BYTES)) == PW'(cmd_q.release_offset);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			cnt_q        <= CW'(1);
			ft_q         <= SW'(POOL_BYTES - HEADER_BYTES);
			we_q         <= 1'b0;
			v_s1         <= 1'b0;
			rsp_valid_q  <= 1'b0;
			ra_q         <= '0;
		end else begin
			we_q <= 1'b0;
			if (!rsp_stall)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					we_q    <= 1'b1;
					wa_q    <= '0;
					wd_q    <= '{free: 1'b1, size: SW'(POOL_BYTES - HEADER_BYTES)};
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q     <= cmd;
						ra_q      <= '0;
						v_s1      <= 1'b0;
						pos_q     <= '0;
						wr_q      <= '0;
						res_off_q <= '0;
						unique case (cmd.command)
							CMD_ALLOC, CMD_FREE: state_q <= S_SCAN;
							CMD_MERGE:           state_q <= S_MERGE;
							default: begin
								res_status_q <= ST_OK;
								state_q      <= S_RESP;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (v_s1 && hit_c) begin
						v_s1         <= 1'b0;
						res_status_q <= ST_OK;
						state_q      <= S_RESP;
						if (cmd_q.command == CMD_FREE) begin
							if (!rd_q.free) begin
								we_q <= 1'b1;
								wa_q <= idx_s1;
								wd_q <= '{free: 1'b1, size: rd_q.size};
								ft_q <= ft_q + rd_q.size;
							end
						end else if (rd_q.size == cmd_q.request_bytes) begin
							we_q      <= 1'b1;
							wa_q      <= idx_s1;
							wd_q      <= '{free: 1'b0, size: rd_q.size};
							ft_q      <= ft_q - rd_q.size;
							res_off_q <= SW'(pos_q + PW'(HEADER_BYTES));
						end else if (PW'(rd_q.size) <= req_hdr_c) begin
							res_status_q <= ST_NO_FIT;
						end else if (cnt_q == CW'(MAX_SEGMENTS)) begin
							res_status_q <= ST_FULL;
						end else begin
							// split: open a slot after the hit by shifting the tail up
							hit_q   <= idx_s1;
							sz_q    <= rd_q.size;
							off_q   <= SW'(pos_q + PW'(HEADER_BYTES));
							ft_q    <= ft_q - SW'(req_hdr_c);
							ra_q    <= cnt_q - CW'(1);
							state_q <= S_SHIFT;
						end
					end else begin
						if (v_s1)
							pos_q <= pos_q + PW'(rd_q.size) + PW'(HEADER_BYTES);
						if (ra_q < cnt_q) begin
							v_s1   <= 1'b1;
							idx_s1 <= ra_q[IW-1:0];
							ra_q   <= ra_q + CW'(1);
						end else begin
							v_s1 <= 1'b0;
						end
						if (!v_s1 && !(ra_q < cnt_q)) begin
							res_status_q <= (cmd_q.command == CMD_ALLOC) ? ST_NO_FIT
							                                             : ST_BAD_FREE;
							state_q <= S_RESP;
						end
					end
				end
				S_MERGE: begin
					// compact in place: acc holds the run being built, wr_q its slot
					if (v_s1) begin
						if (idx_s1 == '0) begin
							acc_q <= rd_q;
						end else if (acc_q.free && rd_q.free) begin
							acc_q.size <= acc_q.size + rd_q.size + SW'(HEADER_BYTES);
							ft_q       <= ft_q + SW'(HEADER_BYTES);
						end else begin
							we_q  <= 1'b1;
							wa_q  <= wr_q;
							wd_q  <= acc_q;
							wr_q  <= wr_q + IW'(1);
							acc_q <= rd_q;
						end
					end
					if (ra_q < cnt_q) begin
						v_s1   <= 1'b1;
						idx_s1 <= ra_q[IW-1:0];
						ra_q   <= ra_q + CW'(1);
					end else begin
						v_s1 <= 1'b0;
					end
					if (!v_s1 && !(ra_q < cnt_q)) begin
						we_q         <= 1'b1;
						wa_q         <= wr_q;
						wd_q         <= acc_q;
						cnt_q        <= CW'(wr_q) + CW'(1);
						res_status_q <= ST_OK;
						state_q      <= S_RESP;
					end
				end
				S_SHIFT: begin
					if (v_s1) begin
						we_q <= 1'b1;
						wa_q <= idx_s1 + IW'(1);
						wd_q <= rd_q;
					end
					if (ra_q > CW'(hit_q)) begin
						v_s1   <= 1'b1;
						idx_s1 <= ra_q[IW-1:0];
						ra_q   <= ra_q - CW'(1);
					end else begin
						v_s1 <= 1'b0;
					end
					if (!v_s1 && !(ra_q > CW'(hit_q)))
						state_q <= S_SPLIT1;
				end
				S_SPLIT1: begin
					we_q    <= 1'b1;
					wa_q    <= hit_q + IW'(1);
					wd_q    <= '{free: 1'b1, size: sz_q - SW'(req_hdr_c)};
					state_q <= S_SPLIT2;
				end
				S_SPLIT2: begin
					we_q         <= 1'b1;
					wa_q         <= hit_q;
					wd_q         <= '{free: 1'b0, size: cmd_q.request_bytes};
					cnt_q        <= cnt_q + CW'(1);
					res_status_q <= ST_OK;
					res_off_q    <= off_q;
					state_q      <= S_RESP;
				end
				S_RESP: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						rsp_q       <= '{status: res_status_q, data_offset: res_off_q,
						                 free_total: ft_q};
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### verif/first_fit_block_allocator_tb.sv
// self-checking testbench of the first-fit block allocator: directed table, then random words
module first_fit_block_allocator_tb;
	import ffba_pkg::*;

	localparam cmd_code_t CMD_SPARE = cmd_code_t'(2'd3);
	localparam int RANDOM_WORDS = 1740;
	localparam int CYCLE_LIMIT  = 2_000_000;

	typedef struct packed {
		cmd_t word;
		logic typed;
		rsp_t result;
	} row_t;

	// rows with typed=1 carry a result read straight off the allocator rules
	localparam row_t DIRECTED[16] = '{
		'{'{CMD_MERGE, 13'd0,    13'd0},    1'b1, '{ST_OK,       13'd0,  13'd4080}},
		'{'{CMD_ALLOC, 13'd4096, 13'd0},    1'b1, '{ST_NO_FIT,   13'd0,  13'd4080}},
		'{'{CMD_ALLOC, 13'd8191, 13'd8191}, 1'b1, '{ST_NO_FIT,   13'd0,  13'd4080}},
		'{'{CMD_ALLOC, 13'd4065, 13'd0},    1'b1, '{ST_NO_FIT,   13'd0,  13'd4080}},
		'{'{CMD_ALLOC, 13'd4080, 13'd0},    1'b1, '{ST_OK,       13'd16, 13'd0}},
		'{'{CMD_FREE,  13'd0,    13'd8191}, 1'b1, '{ST_BAD_FREE, 13'd0,  13'd0}},
		'{'{CMD_FREE,  13'd8191, 13'd16},   1'b1, '{ST_OK,       13'd0,  13'd4080}},
		'{'{CMD_FREE,  13'd0,    13'd16},   1'b1, '{ST_OK,       13'd0,  13'd4080}},
		'{'{CMD_ALLOC, 13'd0,    13'd0},    1'b1, '{ST_OK,       13'd16, 13'd4064}},
		'{'{CMD_FREE,  13'd0,    13'd5},    1'b1, '{ST_BAD_FREE, 13'd0,  13'd4064}},
		'{'{CMD_SPARE, 13'd8191, 13'd8191}, 1'b1, '{ST_OK,       13'd0,  13'd4064}},
		'{'{CMD_ALLOC, 13'd100,  13'd0},    1'b0, '0},
		'{'{CMD_FREE,  13'd0,    13'd16},   1'b0, '0},
		'{'{CMD_FREE,  13'd0,    13'd32},   1'b0, '0},
		'{'{CMD_MERGE, 13'd0,    13'd0},    1'b0, '0},
		'{'{CMD_ALLOC, 13'd3900, 13'd0},    1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	first_fit_block_allocator u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// allocator image: sizes, free marks, segment count
	int seg_size [MAX_SEGMENTS];
	bit seg_free [MAX_SEGMENTS];
	int seg_count;

	rsp_t pending_rsp[$];
	int errors = 0;
	int cycles = 0;
	bit quiet = 1'b0;

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	function automatic int data_off(input int idx);
		int pos;
		pos = 0;
		for (int k = 0; k < idx; k++)
			pos += seg_size[k] + HEADER_BYTES;
		return pos + HEADER_BYTES;
	endfunction

	function automatic rsp_t allocator_step(input cmd_t w);
		rsp_t r;
		int i;
		int req;
		int sum;
		r = '0;
		r.status = ST_OK;
		req = int'(w.request_bytes);
		case (w.command)
			CMD_ALLOC: begin
				for (i = 0; i < seg_count; i++)
					if (seg_free[i] && seg_size[i] >= req)
						break;
				if (i >= seg_count) begin
					r.status = ST_NO_FIT;
				end else if (seg_size[i] == req) begin
					seg_free[i] = 1'b0;
					r.data_offset = SW'(data_off(i));
				end else if (seg_size[i] <= req + HEADER_BYTES) begin
					r.status = ST_NO_FIT;
				end else if (seg_count >= MAX_SEGMENTS) begin
					r.status = ST_FULL;
				end else begin
					for (int j = seg_count; j > i + 1; j--) begin
						seg_size[j] = seg_size[j-1];
						seg_free[j] = seg_free[j-1];
					end
					seg_size[i+1] = seg_size[i] - req - HEADER_BYTES;
					seg_free[i+1] = 1'b1;
					seg_size[i] = req;
					seg_free[i] = 1'b0;
					seg_count++;
					r.data_offset = SW'(data_off(i));
				end
			end
			CMD_FREE: begin
				r.status = ST_BAD_FREE;
				for (i = 0; i < seg_count; i++)
					if (data_off(i) == int'(w.release_offset)) begin
						seg_free[i] = 1'b1;
						r.status = ST_OK;
						break;
					end
			end
			CMD_MERGE: begin
				i = 0;
				while (i + 1 < seg_count) begin
					if (seg_free[i] && seg_free[i+1]) begin
						seg_size[i] += seg_size[i+1] + HEADER_BYTES;
						for (int j = i + 1; j + 1 < seg_count; j++) begin
							seg_size[j] = seg_size[j+1];
							seg_free[j] = seg_free[j+1];
						end
						seg_count--;
						seg_size[seg_count] = 0;
						seg_free[seg_count] = 1'b0;
					end else begin
						i++;
					end
				end
			end
			default: ;
		endcase
		sum = 0;
		for (i = 0; i < seg_count; i++)
			if (seg_free[i])
				sum += seg_size[i];
		r.free_total = sum[SW-1:0];
		return r;
	endfunction

	// random word shaped by phase: fill phases mostly allocate, drain phases mostly free
	function automatic cmd_t random_word(input bit fill);
		cmd_t w;
		int pick;
		int idx;
		int sz;
		w.request_bytes  = SW'($urandom_range(0, 8191));
		w.release_offset = SW'($urandom_range(0, 8191));
		pick = $urandom_range(0, 99);
		if (pick < (fill ? 70 : 25)) begin
			w.command = CMD_ALLOC;
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: sz = $urandom_range(0, 48);
				5, 6: sz = $urandom_range(0, 600);
				7: sz = $urandom_range(0, 4096);
				8: sz = $urandom_range(0, 8191);
				default: begin
					// size near a segment's size: exact fit, too small to split, or a narrow split
					idx = $urandom_range(0, seg_count - 1);
					sz = seg_size[idx] - $urandom_range(0, 20);
					if (sz < 0)
						sz = 0;
				end
			endcase
			w.request_bytes = SW'(sz);
		end else if (pick < (fill ? 85 : 82)) begin
			w.command = CMD_FREE;
			if ($urandom_range(0, 9) < 8) begin
				idx = $urandom_range(0, seg_count - 1);
				w.release_offset = SW'(data_off(idx) + ($urandom_range(0, 9) == 0 ? 1 : 0));
			end
		end else if (pick < 95) begin
			w.command = CMD_MERGE;
		end else begin
			w.command = CMD_SPARE;
		end
		return w;
	endfunction

	task automatic send_word(input cmd_t w, input logic typed, input rsp_t typed_rsp);
		int gap;
		rsp_t predicted;
		gap = quiet ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd <= w;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		predicted = allocator_step(w);
		pending_rsp.push_back(typed ? typed_rsp : predicted);
	endtask

	// response side: random stall stretches, checking each accepted word
	int stall_left = 0;
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("response word with nothing expected");
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						rsp.status, want.status));
				if (rsp.data_offset !== want.data_offset)
					report_mismatch($sformatf("data_offset %0d, expected %0d",
						rsp.data_offset, want.data_offset));
				if (rsp.free_total !== want.free_total)
					report_mismatch($sformatf("free_total %0d, expected %0d",
						rsp.free_total, want.free_total));
			end
			stall_left = quiet ? 0 : $urandom_range(0, 17);
		end
		if (stall_left > 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		for (int k = 0; k < MAX_SEGMENTS; k++) begin
			seg_size[k] = 0;
			seg_free[k] = 1'b0;
		end
		seg_size[0] = POOL_BYTES - HEADER_BYTES;
		seg_free[0] = 1'b1;
		seg_count = 1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[k])
			send_word(DIRECTED[k].word, DIRECTED[k].typed, DIRECTED[k].result);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 60 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			send_word(random_word((n / 60) % 2 == 0), 1'b0, '0);
		end
		cmd_valid <= 1'b0;

		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
